// ===== hw/rtl/qrs_pkg.sv =====
// shared widths, constants and types of the quadratic root solver
package qrs_pkg;

   localparam int COEFF_W    = 32;
   localparam int ROOT_W     = 48;
   localparam int DISC_W     = 66;
   localparam int SQ_IN_W    = 68;
   localparam int SQ_STAGES  = 34;
   localparam int SQ_REM_W   = 36;
   localparam int NUM_W      = 36;
   localparam int DIV_STAGES = 50;

   localparam logic [ROOT_W-1:0] ROOT_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [ROOT_W-1:0] ROOT_MIN = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2,
      CNT_INF  = 2'd3
   } cnt_type;

   typedef struct packed {
      logic [COEFF_W-1:0] a;
      logic [COEFF_W-1:0] b;
      logic [COEFF_W-1:0] c;
      cnt_type            cnt;
   } sq_side_type;

   typedef struct packed {
      logic               neg_lo;
      logic               neg_hi;
      cnt_type            cnt;
      logic [COEFF_W-1:0] divisor;
   } div_side_type;

endpackage

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// pipelined real-root solver for a*x^2 + b*x + c with saturated q32.16 roots
//
//   channel  direction  payload
//   req      in         tdata a, b, c (q16.16 each)
//   rsp      out        tdata root_low, root_high; tuser num_roots, saturated
//
// one transfer per cycle in each direction while rsp is not stalled
// the pipeline holds a 34-stage square root and a 50-stage divider
// reset clears every stage valid bit; payload registers are not reset
// a stalled rsp freezes the whole pipeline, nothing is dropped or repeated
module quadratic_root_solver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coeff_quad, coeff_lin, coeff_const
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // root_low, root_high
   output logic [2:0]  rsp_tuser    // num_roots, saturated
);

   localparam int CW = qrs_pkg::COEFF_W;
   localparam int SQ = qrs_pkg::SQ_STAGES;
   localparam int DV = qrs_pkg::DIV_STAGES;

   logic en;

   // input stage
   logic          s1_v_ff;
   logic [CW-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [CW-1:0] s1_ua, s1_ub, s1_uc;

   // product stage
   logic          s2_v_ff;
   logic [CW-1:0] s2_a_ff, s2_b_ff, s2_c_ff;
   logic [63:0]   s2_bb_ff, s2_ac_ff;
   logic [63:0]   s1_bb, s1_ac;

   // discriminant
   logic [qrs_pkg::DISC_W-1:0] s2_bbx, s2_p4, s2_sum, s2_dif, s2_disc;
   logic                       s2_add, s2_ge;
   qrs_pkg::cnt_type           s2_cnt;

   // square root stages
   logic                          sq_v_ff    [0:SQ];
   logic [qrs_pkg::SQ_REM_W-1:0]  sq_rem_ff  [0:SQ];
   logic [SQ-1:0]                 sq_root_ff [0:SQ];
   logic [qrs_pkg::SQ_IN_W-1:0]   sq_dsh_ff  [0:SQ];
   qrs_pkg::sq_side_type          sq_side_ff [0:SQ];
   logic [qrs_pkg::SQ_REM_W-1:0]  sq_rem_in  [0:SQ];
   logic [SQ-1:0]                 sq_root_in [0:SQ];
   logic [qrs_pkg::SQ_IN_W-1:0]   sq_dsh_in  [0:SQ];
   qrs_pkg::sq_side_type          sq_side_in [0:SQ];

   // divider stages, two lanes sharing one divisor
   logic                  dv_v_ff     [0:DV];
   logic [CW-1:0]         d1_rem_ff   [0:DV];
   logic [DV-1:0]         d1_dq_ff    [0:DV];
   logic [CW-1:0]         d2_rem_ff   [0:DV];
   logic [DV-1:0]         d2_dq_ff    [0:DV];
   qrs_pkg::div_side_type dv_side_ff  [0:DV];
   logic [CW-1:0]         d1_rem_in   [0:DV];
   logic [DV-1:0]         d1_dq_in    [0:DV];
   logic [CW-1:0]         d2_rem_in   [0:DV];
   logic [DV-1:0]         d2_dq_in    [0:DV];
   qrs_pkg::div_side_type dv_side_in  [0:DV];

   // output stage
   logic                      out_v_ff;
   logic [qrs_pkg::ROOT_W-1:0] out_lo_ff, out_hi_ff, out_lo_in, out_hi_in;
   qrs_pkg::cnt_type          out_cnt_ff, out_cnt_in;
   logic                      out_sat_ff, out_sat_in;

   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;

   function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
      return v[CW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [qrs_pkg::ROOT_W:0] fix_root(input logic [DV-1:0] q,
                                                         input logic neg);
      logic [DV-1:0] nq;
      nq = ~q + 1'b1;
      if (!neg && q > {2'b00, qrs_pkg::ROOT_MAX}) begin
         return {1'b1, qrs_pkg::ROOT_MAX};
      end else if (neg && q > {2'b00, qrs_pkg::ROOT_MIN}) begin
         return {1'b1, qrs_pkg::ROOT_MIN};
      end else if (neg) begin
         return {1'b0, nq[qrs_pkg::ROOT_W-1:0]};
      end else begin
         return {1'b0, q[qrs_pkg::ROOT_W-1:0]};
      end
   endfunction

   assign s1_ua = mag(s1_a_ff);
   assign s1_ub = mag(s1_b_ff);
   assign s1_uc = mag(s1_c_ff);
   assign s1_bb = s1_ub * s1_ub;
   assign s1_ac = s1_ua * s1_uc;

   always_comb begin
      s2_bbx  = {2'b00, s2_bb_ff};
      s2_p4   = {s2_ac_ff, 2'b00};
      s2_add  = (s2_c_ff != '0) && (s2_a_ff[CW-1] != s2_c_ff[CW-1]);
      s2_ge   = s2_p4 <= s2_bbx;
      s2_sum  = s2_bbx + s2_p4;
      s2_dif  = s2_bbx - s2_p4;
      s2_disc = s2_add ? s2_sum : (s2_ge ? s2_dif : '0);
      if (s2_a_ff == '0) begin
         if (s2_b_ff == '0) begin
            s2_cnt = (s2_c_ff == '0) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
         end else begin
            s2_cnt = qrs_pkg::CNT_ONE;
         end
      end else if (!s2_add && !s2_ge) begin
         s2_cnt = qrs_pkg::CNT_NONE;
      end else if (s2_disc == '0) begin
         s2_cnt = qrs_pkg::CNT_ONE;
      end else begin
         s2_cnt = qrs_pkg::CNT_TWO;
      end
   end

   // digit-by-digit square root, one root bit per stage
   always_comb begin
      logic [qrs_pkg::SQ_REM_W+1:0] r;
      logic [qrs_pkg::SQ_REM_W+1:0] t;
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      sq_dsh_in[0]  = {2'b00, s2_disc};
      sq_side_in[0] = '{a: s2_a_ff, b: s2_b_ff, c: s2_c_ff, cnt: s2_cnt};
      for (int k = 0; k < SQ; k++) begin
         r = {sq_rem_ff[k], sq_dsh_ff[k][qrs_pkg::SQ_IN_W-1 -: 2]};
         t = {2'b00, sq_root_ff[k], 2'b01};
         if (r >= t) begin
            sq_rem_in[k+1]  = qrs_pkg::SQ_REM_W'(r - t);
            sq_root_in[k+1] = {sq_root_ff[k][SQ-2:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = r[qrs_pkg::SQ_REM_W-1:0];
            sq_root_in[k+1] = {sq_root_ff[k][SQ-2:0], 1'b0};
         end
         sq_dsh_in[k+1]  = {sq_dsh_ff[k][qrs_pkg::SQ_IN_W-3:0], 2'b00};
         sq_side_in[k+1] = sq_side_ff[k];
      end
   end

   // numerators, signs and divisor
   always_comb begin
      qrs_pkg::sq_side_type     sd;
      logic [qrs_pkg::NUM_W-1:0] nb, n1, n2, m1, m2;
      logic [CW-1:0]            uc;
      logic [CW:0]              t1, t2, dvx;
      sd = sq_side_ff[SQ];
      nb = qrs_pkg::NUM_W'(0) - {{(qrs_pkg::NUM_W-CW){sd.b[CW-1]}}, sd.b};
      n1 = nb + {2'b00, sq_root_ff[SQ]};
      n2 = nb - {2'b00, sq_root_ff[SQ]};
      m1 = n1[qrs_pkg::NUM_W-1] ? (~n1 + 1'b1) : n1;
      m2 = n2[qrs_pkg::NUM_W-1] ? (~n2 + 1'b1) : n2;
      uc = mag(sd.c);
      d1_rem_in[0] = '0;
      d2_rem_in[0] = '0;
      dv_side_in[0].cnt = sd.cnt;
      if (sd.a == '0) begin
         d1_dq_in[0] = {2'b00, uc, 16'd0};
         d2_dq_in[0] = {2'b00, uc, 16'd0};
         dv_side_in[0].neg_lo  = ((sd.c != '0) && !sd.c[CW-1]) ^ sd.b[CW-1];
         dv_side_in[0].neg_hi  = ((sd.c != '0) && !sd.c[CW-1]) ^ sd.b[CW-1];
         dv_side_in[0].divisor = mag(sd.b);
      end else begin
         d1_dq_in[0] = {m1[qrs_pkg::NUM_W-2:0], 15'd0};
         d2_dq_in[0] = {m2[qrs_pkg::NUM_W-2:0], 15'd0};
         dv_side_in[0].neg_lo  = n1[qrs_pkg::NUM_W-1] ^ sd.a[CW-1];
         dv_side_in[0].neg_hi  = n2[qrs_pkg::NUM_W-1] ^ sd.a[CW-1];
         dv_side_in[0].divisor = mag(sd.a);
      end
      // restoring division, one quotient bit per stage
      for (int k = 0; k < DV; k++) begin
         dvx = {1'b0, dv_side_ff[k].divisor};
         t1  = {d1_rem_ff[k], d1_dq_ff[k][DV-1]};
         t2  = {d2_rem_ff[k], d2_dq_ff[k][DV-1]};
         if (t1 >= dvx) begin
            d1_rem_in[k+1] = CW'(t1 - dvx);
            d1_dq_in[k+1]  = {d1_dq_ff[k][DV-2:0], 1'b1};
         end else begin
            d1_rem_in[k+1] = t1[CW-1:0];
            d1_dq_in[k+1]  = {d1_dq_ff[k][DV-2:0], 1'b0};
         end
         if (t2 >= dvx) begin
            d2_rem_in[k+1] = CW'(t2 - dvx);
            d2_dq_in[k+1]  = {d2_dq_ff[k][DV-2:0], 1'b1};
         end else begin
            d2_rem_in[k+1] = t2[CW-1:0];
            d2_dq_in[k+1]  = {d2_dq_ff[k][DV-2:0], 1'b0};
         end
         dv_side_in[k+1] = dv_side_ff[k];
      end
   end

   // sign, clipping and ordering
   always_comb begin
      logic [qrs_pkg::ROOT_W:0] f1, f2;
      f1 = fix_root(d1_dq_ff[DV], dv_side_ff[DV].neg_lo);
      f2 = fix_root(d2_dq_ff[DV], dv_side_ff[DV].neg_hi);
      out_cnt_in = dv_side_ff[DV].cnt;
      if (out_cnt_in == qrs_pkg::CNT_NONE || out_cnt_in == qrs_pkg::CNT_INF) begin
         out_lo_in  = '0;
         out_hi_in  = '0;
         out_sat_in = 1'b0;
      end else begin
         out_sat_in = f1[qrs_pkg::ROOT_W] | f2[qrs_pkg::ROOT_W];
         if ($signed(f1[qrs_pkg::ROOT_W-1:0]) < $signed(f2[qrs_pkg::ROOT_W-1:0])) begin
            out_lo_in = f1[qrs_pkg::ROOT_W-1:0];
            out_hi_in = f2[qrs_pkg::ROOT_W-1:0];
         end else begin
            out_lo_in = f2[qrs_pkg::ROOT_W-1:0];
            out_hi_in = f1[qrs_pkg::ROOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= SQ; k++) sq_v_ff[k] <= 1'b0;
         for (int k = 0; k <= DV; k++) dv_v_ff[k] <= 1'b0;
      end else if (en) begin
         s1_v_ff    <= req_tvalid;
         s2_v_ff    <= s1_v_ff;
         sq_v_ff[0] <= s2_v_ff;
         for (int k = 0; k < SQ; k++) sq_v_ff[k+1] <= sq_v_ff[k];
         dv_v_ff[0] <= sq_v_ff[SQ];
         for (int k = 0; k < DV; k++) dv_v_ff[k+1] <= dv_v_ff[k];
         out_v_ff   <= dv_v_ff[DV];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff  <= req_tdata[31:0];
         s1_b_ff  <= req_tdata[63:32];
         s1_c_ff  <= req_tdata[95:64];
         s2_a_ff  <= s1_a_ff;
         s2_b_ff  <= s1_b_ff;
         s2_c_ff  <= s1_c_ff;
         s2_bb_ff <= s1_bb;
         s2_ac_ff <= s1_ac;
         for (int k = 0; k <= SQ; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_dsh_ff[k]  <= sq_dsh_in[k];
            sq_side_ff[k] <= sq_side_in[k];
         end
         for (int k = 0; k <= DV; k++) begin
            d1_rem_ff[k]  <= d1_rem_in[k];
            d1_dq_ff[k]   <= d1_dq_in[k];
            d2_rem_ff[k]  <= d2_rem_in[k];
            d2_dq_ff[k]   <= d2_dq_in[k];
            dv_side_ff[k] <= dv_side_in[k];
         end
         out_lo_ff  <= out_lo_in;
         out_hi_ff  <= out_hi_in;
         out_cnt_ff <= out_cnt_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_hi_ff, out_lo_ff};
   assign rsp_tuser  = {out_sat_ff, out_cnt_ff};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cnt_ff == qrs_pkg::CNT_NONE || out_cnt_ff == qrs_pkg::CNT_INF)
      |-> (out_lo_ff == '0) && (out_hi_ff == '0) && !out_sat_ff)
      else $error("roots not cleared without a finite root");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cnt_ff == qrs_pkg::CNT_ONE) |-> out_lo_ff == out_hi_ff)
      else $error("single root differs between lanes");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_cnt_ff == qrs_pkg::CNT_TWO)
      |-> $signed(out_lo_ff) <= $signed(out_hi_ff))
      else $error("roots out of order");
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");
`endif

endmodule

// ===== tb/quadratic_root_solver_checker.sv =====
// checker for the quadratic root solver: predicts each result and compares it
`timescale 1ns / 1ps
module quadratic_root_solver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          roots_pending
);

   typedef struct packed {
      qrs_pkg::cnt_type           cnt;
      logic [qrs_pkg::ROOT_W-1:0] lo;
      logic [qrs_pkg::ROOT_W-1:0] hi;
      logic                       sat;
   } roots_type;

   roots_type expected_roots[$];

   function automatic logic signed [qrs_pkg::ROOT_W-1:0] clip_root(
      input logic signed [127:0] v, inout logic sat);
      if (v > 128'sh7FFF_FFFF_FFFF) begin
         sat = 1'b1;
         return qrs_pkg::ROOT_MAX;
      end
      if (v < -128'sh8000_0000_0000) begin
         sat = 1'b1;
         return qrs_pkg::ROOT_MIN;
      end
      return v[qrs_pkg::ROOT_W-1:0];
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] d);
      logic [127:0] r;
      logic [127:0] cand;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
         cand = r | (128'd1 << i);
         if (cand * cand <= d) r = cand;
      end
      return r;
   endfunction

   function automatic roots_type solve_roots(input logic [95:0] d);
      logic signed [127:0] a, b, c, disc, s, r1, r2;
      logic signed [qrs_pkg::ROOT_W-1:0] x1, x2;
      roots_type res;
      a = $signed(d[31:0]);
      b = $signed(d[63:32]);
      c = $signed(d[95:64]);
      res = '0;
      res.cnt = qrs_pkg::CNT_NONE;
      if (a == 0) begin
         if (b == 0) begin
            res.cnt = (c == 0) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
         end else begin
            x1 = clip_root((-c * 65536) / b, res.sat);
            res.lo = x1;
            res.hi = x1;
            res.cnt = qrs_pkg::CNT_ONE;
         end
      end else begin
         disc = b * b - 4 * a * c;
         if (disc == 0) begin
            x1 = clip_root((-b * 32768) / a, res.sat);
            res.lo = x1;
            res.hi = x1;
            res.cnt = qrs_pkg::CNT_ONE;
         end else if (disc > 0) begin
            s = floor_sqrt(disc);
            r1 = ((-b + s) * 32768) / a;
            r2 = ((-b - s) * 32768) / a;
            x1 = clip_root(r1, res.sat);
            x2 = clip_root(r2, res.sat);
            res.lo = (x1 < x2) ? x1 : x2;
            res.hi = (x1 < x2) ? x2 : x1;
            res.cnt = qrs_pkg::CNT_TWO;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      roots_type want;
      roots_type got;
      if (reset) begin
         fail_count <= 0;
         roots_pending <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_roots.push_back(solve_roots(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.lo = rsp_tdata[47:0];
            got.hi = rsp_tdata[95:48];
            got.cnt = qrs_pkg::cnt_type'(rsp_tuser[1:0]);
            got.sat = rsp_tuser[2];
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected transfer %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (got !== want) begin
                  $display("%0t: expected cnt %0d lo %h hi %h sat %b, got cnt %0d lo %h hi %h sat %b",
                     $time, want.cnt, want.lo, want.hi, want.sat,
                     got.cnt, got.lo, got.hi, got.sat);
                  fail_count <= fail_count + 1;
               end
            end
         end
         roots_pending <= expected_roots.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// top of the quadratic root solver testbench: stimulus, idle and stall phases and verdict
`timescale 1ns / 1ps
module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          fail_count;
   int          roots_pending;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   quadratic_root_solver_unit u_top (.*);

   quadratic_root_solver_checker u_checker (.*);

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall);

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return $urandom_range(8) << 16;
         4: return -($urandom_range(8) << 16);
         5: return $signed($urandom_range(4095)) - 2048;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_equation(input logic [31:0] a, b, c);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] r, s, a;
      case ($urandom_range(5))
         0: begin
            r = $signed($urandom_range(255)) - 128;
            s = $signed($urandom_range(255)) - 128;
            a = $urandom_range(1) ? 32'h10000 : 32'hFFFF0000;
            send_equation(a, -(r + s) * $signed(a) >>> 0 << 0,
               $signed(r) * $signed(s) * $signed(a));
         end
         1: begin
            r = $signed($urandom_range(511)) - 256;
            send_equation(32'h10000, -2 * $signed(r), ($signed(r) * $signed(r)) >>> 16);
         end
         2: send_equation(0, pick_coeff(), pick_coeff());
         default: send_equation(pick_coeff(), pick_coeff(), pick_coeff());
      endcase
   endtask

   initial begin
      int phase_idle[4];
      int phase_stall[4];
      phase_idle  = '{0, 63, 0, 19};
      phase_stall = '{0, 0, 63, 19};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_equation(0, 0, 0);
      send_equation(0, 0, 32'h10000);
      send_equation(0, 32'h20000, 32'hFFFC0000);
      send_equation(0, 32'h1, 32'h8000_0000);
      send_equation(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_equation(32'h10000, 0, 32'h10000);
      send_equation(32'h10000, 32'hFFFE0000, 32'h10000);
      send_equation(32'h10000, 0, 32'hFFFF0000);
      send_equation(32'h1, 32'h7FFF_FFFF, 0);
      send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_equation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_equation(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_equation(32'hFFFF_FFFF, 32'h8000_0000, 32'h1);
      send_equation(32'h1, 32'h8000_0000, 32'h8000_0000);
      send_equation(32'hFFFFFFFF, 0, 32'hFFFFFFFF);
      send_equation(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_equation(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      for (int p = 0; p < 4; p++) begin
         send_idle = phase_idle[p];
         recv_stall = phase_stall[p];
         for (int i = 0; i < 310; i++) send_random();
      end
      req_tvalid <= 0;
      send_idle = 0;
      recv_stall = 0;
      while (roots_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && roots_pending == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
